FILE: rtl/thpm_pkg.sv
package thpm_pkg;

    localparam int TRIE_ENTRIES = 16384;
    localparam int OP_ENTRIES   = 512;
    localparam int MAX_WORD     = 63;

    localparam int TRIE_AW  = $clog2(TRIE_ENTRIES);
    localparam int OP_AW    = $clog2(OP_ENTRIES);
    localparam int STEP_W   = OP_AW + 1;
    localparam int WB_DEPTH = MAX_WORD + 1;
    localparam int WB_AW    = $clog2(WB_DEPTH);
    localparam int VS_DEPTH = MAX_WORD + 3;
    localparam int VS_AW    = $clog2(VS_DEPTH);
    localparam int TRIE_W   = 30;
    localparam int OPE_W    = 20;

    localparam logic [8:0] BOUNDARY_CODE = 9'd256;

    typedef enum logic [1:0] {
        CMD_TRIE   = 2'd0,
        CMD_OPER   = 2'd1,
        CMD_LETTER = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_LANGUAGE  = 2'd0,
        CFG_LEFT_MIN  = 2'd1,
        CFG_RIGHT_MIN = 2'd2,
        CFG_OP_OFFSET = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] language;
        logic [5:0] left_min;
        logic [5:0] right_min;
        logic [8:0] op_offset;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,
        S_ROOTCHK,
        S_WBRD,
        S_ZADDR,
        S_NODE,
        S_ADV,
        S_NEXTJ,
        S_OPRD,
        S_OPDATA,
        S_VAL,
        S_ORD,
        S_OSEND
    } state_t;

endpackage

FILE: rtl/thpm_ram.sv
module thpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/thpm_engine.sv
module thpm_engine
    import thpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_cmd,
    input  logic [71:0] in_data,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  out_position,
    output logic [5:0]  out_value,
    output logic        out_last
);

    state_t state_reg, state_next;

    logic [6:0]           cnt_reg;
    logic [6:0]           n_reg;
    logic [6:0]           j_reg;
    logic [6:0]           l_reg;
    logic [6:0]           k_reg;
    logic [13:0]          base_reg;
    logic [13:0]          root_link_reg;
    logic [8:0]           code_reg;
    logic [7:0]           v_reg;
    logic [STEP_W-1:0]    steps_reg;
    logic [VS_AW-1:0]     pos_reg;
    logic [5:0]           val_reg;
    logic [VS_DEPTH-1:0]  valid_reg;

    logic [13:0] f_address;
    logic [7:0]  f_entry_char;
    logic [13:0] f_entry_link;
    logic [7:0]  f_entry_op;
    logic [5:0]  f_op_distance;
    logic [5:0]  f_op_value;
    logic [7:0]  f_op_next;
    logic [7:0]  f_letter;

    assign f_address     = in_data[13:0];
    assign f_entry_char  = in_data[21:14];
    assign f_entry_link  = in_data[35:22];
    assign f_entry_op    = in_data[43:36];
    assign f_op_distance = in_data[49:44];
    assign f_op_value    = in_data[55:50];
    assign f_op_next     = in_data[63:56];
    assign f_letter      = in_data[71:64];

    logic               accept;
    logic               trie_we, trie_re;
    logic [TRIE_AW-1:0] trie_waddr, trie_raddr;
    logic [TRIE_W-1:0]  trie_rdata;
    logic               op_we, op_re;
    logic [OP_AW-1:0]   op_waddr, op_raddr;
    logic [OPE_W-1:0]   op_rdata;
    logic               wb_we, wb_re;
    logic [WB_AW-1:0]   wb_raddr;
    logic [7:0]         wb_rdata;
    logic               vs_we, vs_re;
    logic [VS_AW-1:0]   vs_raddr;
    logic [5:0]         vs_rdata;

    logic [6:0]  cnt_inc;
    logic [8:0]  code;
    logic        node_match;
    logic [7:0]  walk_lim;
    logic [6:0]  j_inc;
    logic        more_j;
    logic [7:0]  op_pos;
    logic        op_pos_ok;
    logic        chain_more_data;
    logic        chain_more_val;
    logic [5:0]  cur_val;
    logic        raise;
    logic        edge_clr;
    logic        root_ok;

    assign accept  = in_valid && in_ready;
    assign cnt_inc = (cnt_reg < 7'(MAX_WORD)) ? cnt_reg + 7'd1 : cnt_reg;

    // last start position that can still reach a break outside right_min
    assign walk_lim = {1'b0, n_reg} - {2'b00, cfg.right_min} + 8'd1;
    assign j_inc    = j_reg + 7'd1;
    assign more_j   = $signed({1'b0, j_inc}) <= $signed(walk_lim);
    assign root_ok  = (trie_rdata[7:0] == cfg.language) && !walk_lim[7];

    always_comb
    begin
        priority if (l_reg == 7'd0)
            code = 9'd0;
        else if (l_reg <= n_reg)
            code = {1'b0, wb_rdata};
        else if (l_reg == n_reg + 7'd1)
            code = 9'd0;
        else
            code = BOUNDARY_CODE;
    end

    assign node_match = (code_reg == {1'b0, trie_rdata[7:0]});

    assign op_pos    = {1'b0, l_reg} - {2'b00, op_rdata[5:0]};
    assign op_pos_ok = !op_pos[7];
    assign chain_more_data = (op_rdata[19:12] != 8'd0) && (steps_reg != STEP_W'(OP_ENTRIES));
    assign chain_more_val  = (v_reg != 8'd0) && (steps_reg != STEP_W'(OP_ENTRIES));

    assign cur_val  = valid_reg[pos_reg] ? vs_rdata : 6'd0;
    assign raise    = val_reg > cur_val;
    assign edge_clr = (k_reg < {1'b0, cfg.left_min}) || ((n_reg - k_reg) < {1'b0, cfg.right_min});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd_t'(in_cmd) == CMD_LETTER && in_last)
                    state_next = S_ROOT;
            end
            S_ROOT:    state_next = S_ROOTCHK;
            S_ROOTCHK: state_next = root_ok ? S_WBRD : S_ORD;
            S_WBRD:    state_next = S_ZADDR;
            S_ZADDR:   state_next = S_NODE;
            S_NODE:
            begin
                if (!node_match)
                    state_next = S_NEXTJ;
                else if (trie_rdata[29:22] != 8'd0)
                    state_next = S_OPRD;
                else
                    state_next = S_ADV;
            end
            S_ADV:     state_next = (l_reg + 7'd1 > n_reg + 7'd2) ? S_NEXTJ : S_WBRD;
            S_NEXTJ:   state_next = more_j ? S_WBRD : S_ORD;
            S_OPRD:    state_next = S_OPDATA;
            S_OPDATA:
            begin
                if (op_pos_ok)
                    state_next = S_VAL;
                else
                    state_next = chain_more_data ? S_OPRD : S_ADV;
            end
            S_VAL:     state_next = chain_more_val ? S_OPRD : S_ADV;
            S_ORD:     state_next = S_OSEND;
            S_OSEND:
            begin
                if (out_ready)
                    state_next = (k_reg == n_reg) ? S_IDLE : S_ORD;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_OSEND);
        trie_we    = accept && cmd_t'(in_cmd) == CMD_TRIE;
        trie_waddr = TRIE_AW'(f_address);
        op_we      = accept && cmd_t'(in_cmd) == CMD_OPER;
        op_waddr   = OP_AW'(f_address);
        wb_we      = accept && cmd_t'(in_cmd) == CMD_LETTER && (cnt_reg < 7'(MAX_WORD));
        trie_re    = 1'b0;
        trie_raddr = TRIE_AW'({1'b0, cfg.language} + 9'd1);
        op_re      = 1'b0;
        op_raddr   = OP_AW'(cfg.op_offset + {1'b0, v_reg} - 9'd1);
        wb_re      = 1'b0;
        wb_raddr   = WB_AW'(l_reg - 7'd1);
        vs_re      = 1'b0;
        vs_raddr   = VS_AW'(op_pos);
        vs_we      = 1'b0;
        unique case (state_reg)
            S_ROOT:   trie_re = 1'b1;
            S_WBRD:   wb_re   = 1'b1;
            S_ZADDR:
            begin
                trie_re    = 1'b1;
                trie_raddr = TRIE_AW'({1'b0, base_reg} + {6'd0, code});
            end
            S_OPRD:   op_re = 1'b1;
            S_OPDATA: vs_re = op_pos_ok;
            S_VAL:    vs_we = raise;
            S_ORD:
            begin
                vs_re    = 1'b1;
                vs_raddr = VS_AW'(k_reg);
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 7'd0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd_t'(in_cmd) == CMD_LETTER)
                    begin
                        if (in_last)
                        begin
                            cnt_reg   <= 7'd0;
                            valid_reg <= '0;
                        end
                        else
                        begin
                            cnt_reg <= cnt_inc;
                        end
                    end
                end
                S_VAL:
                begin
                    if (raise)
                        valid_reg[pos_reg] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd_t'(in_cmd) == CMD_LETTER && in_last)
                    n_reg <= cnt_inc;
            end
            S_ROOTCHK:
            begin
                base_reg      <= trie_rdata[21:8];
                root_link_reg <= trie_rdata[21:8];
                j_reg         <= 7'd0;
                l_reg         <= 7'd0;
                k_reg         <= 7'd0;
            end
            S_ZADDR:  code_reg <= code;
            S_NODE:
            begin
                base_reg  <= trie_rdata[21:8];
                v_reg     <= trie_rdata[29:22];
                steps_reg <= '0;
            end
            S_ADV:    l_reg <= l_reg + 7'd1;
            S_NEXTJ:
            begin
                j_reg    <= j_inc;
                l_reg    <= j_inc;
                base_reg <= root_link_reg;
                k_reg    <= 7'd0;
            end
            S_OPRD:   steps_reg <= steps_reg + STEP_W'(1);
            S_OPDATA:
            begin
                v_reg   <= op_rdata[19:12];
                val_reg <= op_rdata[11:6];
                pos_reg <= VS_AW'(op_pos);
            end
            S_OSEND:
            begin
                if (out_ready)
                    k_reg <= k_reg + 7'd1;
            end
            default: ;
        endcase
    end

    assign out_position = k_reg[5:0];
    assign out_value    = (valid_reg[VS_AW'(k_reg)] && !edge_clr) ? vs_rdata : 6'd0;
    assign out_last     = (k_reg == n_reg);

    thpm_ram #(.WIDTH(TRIE_W), .DEPTH(TRIE_ENTRIES)) u_trie (
        .clk   (clk),
        .we    (trie_we),
        .waddr (trie_waddr),
        .wdata ({f_entry_op, f_entry_link, f_entry_char}),
        .re    (trie_re),
        .raddr (trie_raddr),
        .rdata (trie_rdata)
    );

    thpm_ram #(.WIDTH(OPE_W), .DEPTH(OP_ENTRIES)) u_ops (
        .clk   (clk),
        .we    (op_we),
        .waddr (op_waddr),
        .wdata ({f_op_next, f_op_value, f_op_distance}),
        .re    (op_re),
        .raddr (op_raddr),
        .rdata (op_rdata)
    );

    thpm_ram #(.WIDTH(8), .DEPTH(WB_DEPTH)) u_word (
        .clk   (clk),
        .we    (wb_we),
        .waddr (WB_AW'(cnt_reg)),
        .wdata (f_letter),
        .re    (wb_re),
        .raddr (wb_raddr),
        .rdata (wb_rdata)
    );

    thpm_ram #(.WIDTH(6), .DEPTH(VS_DEPTH)) u_vals (
        .clk   (clk),
        .we    (vs_we),
        .waddr (pos_reg),
        .wdata (val_reg),
        .re    (vs_re),
        .raddr (vs_raddr),
        .rdata (vs_rdata)
    );

endmodule

FILE: rtl/trie_hyphenation_pattern_matcher_core.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: table writes and letters, tuser: command, tlast
// m_*       out  m_tvalid/m_tready  tdata: position, value, break flag; tlast: final position
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Table writes and letters are accepted only while idle. After the final letter the trie walk
// runs on the single trie read port: S_WBRD, S_ZADDR, S_NODE per visited node, S_OPRD and
// S_OPDATA (and S_VAL if in range) per operation followed, then S_ORD, S_OSEND per result.
// Reset clears control state only; the trie and operation memories must be written first.
// m_tready low holds the current result; input stays blocked until the last one goes.
module trie_hyphenation_pattern_matcher_core
    import thpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address, entry_char, entry_link, entry_op, op_distance, op_value, op_next, letter
    input  logic [71:0] s_tdata,
    // operation
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // position, hyph_value, break_allowed, zero fill
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    cfg_t       cfg_reg;
    logic [5:0] out_position;
    logic [5:0] out_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.language  <= 8'd0;
            cfg_reg.left_min  <= 6'd2;
            cfg_reg.right_min <= 6'd3;
            cfg_reg.op_offset <= 9'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LANGUAGE:  cfg_reg.language  <= cfg_data[7:0];
                CFG_LEFT_MIN:  cfg_reg.left_min  <= cfg_data[5:0];
                CFG_RIGHT_MIN: cfg_reg.right_min <= cfg_data[5:0];
                CFG_OP_OFFSET: cfg_reg.op_offset <= cfg_data;
                default: ;
            endcase
        end
    end

    thpm_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_cmd       (s_tuser),
        .in_data      (s_tdata),
        .in_last      (s_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_position (out_position),
        .out_value    (out_value),
        .out_last     (m_tlast)
    );

    assign m_tdata = {3'b000, out_value[0], out_value, out_position};

endmodule
